[hdl/lpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared widths, codes and payload types of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // Coordinate width of the endpoint and pixel fields.
    localparam int COORD_BITS  = 12;
    // Signed differences of two coordinates need one more bit.
    localparam int DELTA_BITS  = COORD_BITS + 1;
    // Error term, thresholds and increments reach about four run lengths.
    localparam int ERR_BITS    = COORD_BITS + 3;
    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Function codes of an input item.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Line kind codes reported with every pixel.
    typedef enum logic [1:0] {
        KIND_HORIZONTAL = 2'd0,
        KIND_POS_SLOPE  = 2'd1,
        KIND_NEG_SLOPE  = 2'd2,
        KIND_VERTICAL   = 2'd3
    } lpg_kind_t;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CLEAR = 2'd2
    } lpg_op_t;

    // Input item.
    typedef struct packed {
        logic                          func;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
    } lpg_in_t;

    // Result item.
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic [1:0]                    line_kind;
        logic                          last_pixel;
    } lpg_out_t;

    // Classified command, already ordered along the major axis.
    typedef struct packed {
        lpg_op_t                       op;
        logic                          y_major;
        lpg_kind_t                     kind;
        logic signed [COORD_BITS-1:0]  major_start;
        logic signed [COORD_BITS-1:0]  major_limit;
        logic signed [COORD_BITS-1:0]  minor_start;
        logic signed [DELTA_BITS-1:0]  delta_major;
        logic signed [DELTA_BITS-1:0]  delta_minor;
    } lpg_cmd_t;

endpackage

[hdl/lpg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Accepts input items and classifies them into queue commands: steps pass
// through, loads are sorted along the major axis with their deltas and kind.
// ----------------------------------------------------------------------------
module lpg_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  lpg_pkg::lpg_in_t  s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output lpg_pkg::lpg_cmd_t q_data
);

    localparam int CB = lpg_pkg::COORD_BITS;
    localparam int DB = lpg_pkg::DELTA_BITS;

    logic signed [DB-1:0] sx, sy, ex, ey;
    logic signed [DB-1:0] dx, dy, ndx, ndy;
    logic signed [DB-1:0] adx, ady;
    logic                 zero_len;
    logic                 y_major;

    // A transfer goes straight into the queue.
    assign q_valid = s_valid;
    assign s_ready = q_ready;

    // Endpoint differences in both directions, so no negation follows.
    assign sx  = {s_data.start_x[CB-1], s_data.start_x};
    assign sy  = {s_data.start_y[CB-1], s_data.start_y};
    assign ex  = {s_data.end_x[CB-1], s_data.end_x};
    assign ey  = {s_data.end_y[CB-1], s_data.end_y};
    assign dx  = ex - sx;
    assign dy  = ey - sy;
    assign ndx = sx - ex;
    assign ndy = sy - ey;
    assign adx = dx[DB-1] ? ndx : dx;
    assign ady = dy[DB-1] ? ndy : dy;

    assign zero_len = (s_data.start_x == s_data.end_x) && (s_data.start_y == s_data.end_y);
    // Ties on the diagonal go to the y axis.
    assign y_major  = !(adx > ady);

    // Build the command.
    always_comb begin
        q_data         = '0;
        q_data.y_major = y_major;

        if (s_data.func == lpg_pkg::FUNC_STEP) begin
            q_data.op = lpg_pkg::OP_STEP;
        end else if (zero_len) begin
            q_data.op = lpg_pkg::OP_CLEAR;
        end else begin
            q_data.op = lpg_pkg::OP_LOAD;
        end

        if (dy == '0) begin
            q_data.kind = lpg_pkg::KIND_HORIZONTAL;
        end else if (dx == '0) begin
            q_data.kind = lpg_pkg::KIND_VERTICAL;
        end else if (dx[DB-1] == dy[DB-1]) begin
            q_data.kind = lpg_pkg::KIND_POS_SLOPE;
        end else begin
            q_data.kind = lpg_pkg::KIND_NEG_SLOPE;
        end

        // Order the endpoints so the run goes up the major axis.
        if (!y_major) begin
            if (!dx[DB-1]) begin
                q_data.major_start = s_data.start_x;
                q_data.major_limit = s_data.end_x;
                q_data.minor_start = s_data.start_y;
                q_data.delta_major = dx;
                q_data.delta_minor = dy;
            end else begin
                q_data.major_start = s_data.end_x;
                q_data.major_limit = s_data.start_x;
                q_data.minor_start = s_data.end_y;
                q_data.delta_major = ndx;
                q_data.delta_minor = ndy;
            end
        end else begin
            if (!dy[DB-1]) begin
                q_data.major_start = s_data.start_y;
                q_data.major_limit = s_data.end_y;
                q_data.minor_start = s_data.start_x;
                q_data.delta_major = dy;
                q_data.delta_minor = dx;
            end else begin
                q_data.major_start = s_data.end_y;
                q_data.major_limit = s_data.start_y;
                q_data.minor_start = s_data.end_x;
                q_data.delta_major = ndy;
                q_data.delta_minor = ndx;
            end
        end
    end

endmodule

[hdl/lpg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lpg_queue #(
    parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  lpg_pkg::lpg_cmd_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output lpg_pkg::lpg_cmd_t pop_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lpg_pkg::lpg_cmd_t entry_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push_fire, pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CW'(DEPTH))
        else $error("queue fill count above depth");

    // A lone push raises the count by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

[hdl/lpg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator back end
// Holds the active run, executes load and step commands and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module lpg_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  lpg_pkg::lpg_cmd_t q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lpg_pkg::lpg_out_t m_data
);

    localparam int CB = lpg_pkg::COORD_BITS;
    localparam int DB = lpg_pkg::DELTA_BITS;
    localparam int EB = lpg_pkg::ERR_BITS;

    // Run state.
    logic                 active_reg, active_next;
    logic signed [CB-1:0] major_pos_reg, major_pos_next;
    logic signed [CB-1:0] major_lim_reg, major_lim_next;
    logic signed [CB-1:0] minor_pos_reg, minor_pos_next;
    logic signed [EB-1:0] err_reg, err_next;
    logic signed [EB-1:0] thr_hi_reg, thr_hi_next;
    logic signed [EB-1:0] thr_lo_reg, thr_lo_next;
    logic signed [EB-1:0] inc_up_reg, inc_up_next;
    logic signed [EB-1:0] inc_mid_reg, inc_mid_next;
    logic signed [EB-1:0] inc_dn_reg, inc_dn_next;
    logic                 y_major_reg, y_major_next;
    logic [1:0]           kind_reg, kind_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    lpg_pkg::lpg_out_t    m_data_reg, m_data_next;

    logic                 out_free;
    logic                 pop_fire;
    logic                 step_fire;
    logic                 is_last;
    logic signed [DB-1:0] pos_ext, lim_ext, pos_inc;
    logic signed [EB-1:0] dm_ext, de_ext, two_d, two_e, sum_de;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A step with a live run needs room in the output register.
    assign out_free  = !m_valid_reg || m_ready;
    assign q_ready   = (q_data.op != lpg_pkg::OP_STEP) || !active_reg || out_free;
    assign pop_fire  = q_valid && q_ready;
    assign step_fire = pop_fire && (q_data.op == lpg_pkg::OP_STEP) && active_reg;

    // Final pixel test on the major axis.
    assign pos_ext = {major_pos_reg[CB-1], major_pos_reg};
    assign lim_ext = {major_lim_reg[CB-1], major_lim_reg};
    assign pos_inc = pos_ext + DB'(1);
    assign is_last = (pos_inc >= lim_ext);

    // Per-run thresholds and increments of the error term.
    assign dm_ext = {{(EB - DB){q_data.delta_major[DB-1]}}, q_data.delta_major};
    assign de_ext = {{(EB - DB){q_data.delta_minor[DB-1]}}, q_data.delta_minor};
    assign two_d  = {dm_ext[EB-2:0], 1'b0};
    assign two_e  = {de_ext[EB-2:0], 1'b0};
    assign sum_de = dm_ext + two_e;

    // Command execution.
    always_comb begin
        active_next    = active_reg;
        major_pos_next = major_pos_reg;
        major_lim_next = major_lim_reg;
        minor_pos_next = minor_pos_reg;
        err_next       = err_reg;
        thr_hi_next    = thr_hi_reg;
        thr_lo_next    = thr_lo_reg;
        inc_up_next    = inc_up_reg;
        inc_mid_next   = inc_mid_reg;
        inc_dn_next    = inc_dn_reg;
        y_major_next   = y_major_reg;
        kind_next      = kind_reg;

        if (pop_fire) begin
            case (q_data.op)
                lpg_pkg::OP_LOAD: begin
                    active_next    = 1'b1;
                    major_pos_next = q_data.major_start;
                    major_lim_next = q_data.major_limit;
                    minor_pos_next = q_data.minor_start;
                    err_next       = '0;
                    thr_hi_next    = dm_ext - two_e;
                    thr_lo_next    = -sum_de;
                    inc_up_next    = two_e - two_d;
                    inc_mid_next   = two_e;
                    inc_dn_next    = two_e + two_d;
                    y_major_next   = q_data.y_major;
                    kind_next      = q_data.kind;
                end
                lpg_pkg::OP_CLEAR: begin
                    active_next = 1'b0;
                end
                lpg_pkg::OP_STEP: begin
                    if (active_reg) begin
                        if (is_last) begin
                            active_next = 1'b0;
                        end else begin
                            major_pos_next = pos_inc[CB-1:0];
                            if (err_reg >= thr_hi_reg) begin
                                err_next       = err_reg + inc_up_reg;
                                minor_pos_next = minor_pos_reg + 1'b1;
                            end else if (err_reg < thr_lo_reg) begin
                                err_next       = err_reg + inc_dn_reg;
                                minor_pos_next = minor_pos_reg - 1'b1;
                            end else begin
                                err_next = err_reg + inc_mid_reg;
                            end
                        end
                    end
                end
                default: begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    // Result register: loads a pixel on a step, drains on a transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (step_fire) begin
            m_valid_next           = 1'b1;
            m_data_next.pixel_x    = y_major_reg ? minor_pos_reg : major_pos_reg;
            m_data_next.pixel_y    = y_major_reg ? major_pos_reg : minor_pos_reg;
            m_data_next.line_kind  = kind_reg;
            m_data_next.last_pixel = is_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        major_pos_reg <= major_pos_next;
        major_lim_reg <= major_lim_next;
        minor_pos_reg <= minor_pos_next;
        err_reg       <= err_next;
        thr_hi_reg    <= thr_hi_next;
        thr_lo_reg    <= thr_lo_next;
        inc_up_reg    <= inc_up_next;
        inc_mid_reg   <= inc_mid_next;
        inc_dn_reg    <= inc_dn_next;
        y_major_reg   <= y_major_next;
        kind_reg      <= kind_next;
        m_data_reg    <= m_data_next;
    end

    // A live run always has pixels left before its limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (major_pos_reg < major_lim_reg))
        else $error("active run past its limit");

    // The lower error threshold stays below the upper one for a live run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (thr_lo_reg < thr_hi_reg))
        else $error("error thresholds out of order");

    // The final pixel ends the run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && is_last) |=> !active_reg)
        else $error("run still active after its last pixel");

endmodule

[hdl/line_pixel_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator core
// Rasterizes a line given by two endpoints, one pixel per step item.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes items. A load (func 0) latches two endpoints and
//   produces nothing; each step (func 1) then produces the next pixel of the
//   line on the m_ channel, with last_pixel set on the final one. Steps with
//   no line in progress, and all steps after a zero-length load, produce no
//   transfer. A new load replaces any line in progress.
//   Timing: a step is written into the command queue at its input transfer
//   edge and later executed from the queue into the output register, which
//   raises m_valid for its pixel; back-pressure can hold it in the queue.
//   Items are taken at 1 per cycle while the output register keeps draining;
//   each step costs one add and two compares against per-run thresholds
//   prepared at load time.
//   Reset: aresetn low at a clock edge empties the command queue, drops any
//   line in progress and clears m_valid.
//   Back-pressure: when m_ready is low the pixel waits in the output register,
//   the back end holds the next step of a live run, and the command queue
//   keeps taking items until it is full, after which s_ready goes low.
// ----------------------------------------------------------------------------
module line_pixel_generator_core #(
    parameter int QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lpg_pkg::lpg_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lpg_pkg::lpg_out_t m_data
);

    logic              push_valid, push_ready;
    lpg_pkg::lpg_cmd_t push_data;
    logic              pop_valid, pop_ready;
    lpg_pkg::lpg_cmd_t pop_data;

    // Classification of input items.
    lpg_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (push_valid),
        .q_ready (push_ready),
        .q_data  (push_data)
    );

    // Command queue between the two halves.
    lpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Run execution and result register.
    lpg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_data  (pop_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[sim/line_pixel_generator_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator core testbench
// Sends endpoint loads and pixel steps on s_, with random gaps in most parts.
// An in-bench rasterizer predicts every pixel, and each m_ transfer is
// compared field by field with the oldest predicted pixel. Directed lines
// come first, then random lines of mostly short runs with some noise.
// ----------------------------------------------------------------------------
module line_pixel_generator_core_test;

    localparam int CB = lpg_pkg::COORD_BITS;
    localparam int DB = lpg_pkg::DELTA_BITS;
    localparam int EB = lpg_pkg::ERR_BITS;
    localparam int COORD_MAX  = (1 << (CB - 1)) - 1;
    localparam int COORD_MIN  = -COORD_MAX - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    lpg_pkg::lpg_in_t   s_data;
    logic               m_valid;
    logic               m_ready;
    lpg_pkg::lpg_out_t  m_data;

    // Pixels predicted but not yet seen on the m_ channel.
    lpg_pkg::lpg_out_t  expected_pixels[$];
    int        mismatch_count = 0;
    int        items_counted  = 0;
    int        quiet_cycles   = 0;
    bit        idling_on      = 1'b1;

    // Rasterizer state, kept at the widths of the block.
    logic                   line_on;
    logic signed [CB-1:0]   major_pos;
    logic signed [CB-1:0]   major_end;
    logic signed [CB-1:0]   minor_pos;
    logic signed [EB-1:0]   err_acc;
    logic signed [DB-1:0]   span_major;
    logic signed [DB-1:0]   span_minor;
    logic                   y_major;
    lpg_pkg::lpg_kind_t     run_kind;

    line_pixel_generator_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with a 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Rasterizer state after reset.
    task automatic clear_rasterizer();
        line_on    = 1'b0;
        major_pos  = '0;
        major_end  = '0;
        minor_pos  = '0;
        err_acc    = '0;
        span_major = '0;
        span_minor = '0;
        y_major    = 1'b0;
        run_kind   = lpg_pkg::KIND_HORIZONTAL;
    endtask

    // Updates the rasterizer for one accepted item. Returns 1 when the item
    // yields a pixel, which is then queued as an expected transfer.
    function automatic bit rasterize_item(input lpg_pkg::lpg_in_t item);
        int                sx, sy, ex, ey, dx, dy, adx, ady;
        int                p0, q0, p1, q1, err;
        lpg_pkg::lpg_out_t pixel;
        bit                last;
        if (item.func == lpg_pkg::FUNC_LOAD) begin
            sx = item.start_x;
            sy = item.start_y;
            ex = item.end_x;
            ey = item.end_y;
            dx = ex - sx;
            dy = ey - sy;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            if (dx == 0 && dy == 0) begin
                line_on = 1'b0;
                return 1'b0;
            end
            if (dy == 0)
                run_kind = lpg_pkg::KIND_HORIZONTAL;
            else if (dx == 0)
                run_kind = lpg_pkg::KIND_VERTICAL;
            else if ((dx > 0) == (dy > 0))
                run_kind = lpg_pkg::KIND_POS_SLOPE;
            else
                run_kind = lpg_pkg::KIND_NEG_SLOPE;
            // Ties between the axes go to y.
            y_major = !(adx > ady);
            if (!y_major) begin
                if (sx <= ex) begin
                    p0 = sx; q0 = sy; p1 = ex; q1 = ey;
                end else begin
                    p0 = ex; q0 = ey; p1 = sx; q1 = sy;
                end
            end else begin
                if (sy <= ey) begin
                    p0 = sy; q0 = sx; p1 = ey; q1 = ex;
                end else begin
                    p0 = ey; q0 = ex; p1 = sy; q1 = sx;
                end
            end
            major_pos  = CB'(p0);
            major_end  = CB'(p1);
            minor_pos  = CB'(q0);
            span_major = DB'(p1 - p0);
            span_minor = DB'(q1 - q0);
            err_acc    = '0;
            line_on    = 1'b1;
            return 1'b0;
        end
        if (!line_on)
            return 1'b0;
        // Emit the current pixel, then advance along the major axis.
        last = (int'(major_pos) + 1) >= int'(major_end);
        pixel.pixel_x    = y_major ? minor_pos : major_pos;
        pixel.pixel_y    = y_major ? major_pos : minor_pos;
        pixel.line_kind  = run_kind;
        pixel.last_pixel = last;
        expected_pixels.push_back(pixel);
        if (last) begin
            line_on = 1'b0;
        end else begin
            major_pos = CB'(int'(major_pos) + 1);
            err = int'(err_acc) + 2 * int'(span_minor);
            if (err >= int'(span_major)) begin
                err = err - 2 * int'(span_major);
                minor_pos = CB'(int'(minor_pos) + 1);
            end else if (err < -int'(span_major)) begin
                err = err + 2 * int'(span_major);
                minor_pos = CB'(int'(minor_pos) - 1);
            end
            err_acc = EB'(err);
        end
        return 1'b1;
    endfunction

    // Sends one item, starting and ending at a falling edge.
    task automatic send_item(input lpg_pkg::lpg_in_t item);
        bit produced;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do
            @(posedge aclk);
        while (!s_ready);
        produced = rasterize_item(item);
        if (item.func == lpg_pkg::FUNC_LOAD || produced)
            items_counted++;
        @(negedge aclk);
    endtask

    task automatic send_load(input int sx, input int sy, input int ex, input int ey);
        lpg_pkg::lpg_in_t item;
        item.func    = lpg_pkg::FUNC_LOAD;
        item.start_x = CB'(sx);
        item.start_y = CB'(sy);
        item.end_x   = CB'(ex);
        item.end_y   = CB'(ey);
        send_item(item);
    endtask

    // A step carries random coordinates, which the block must ignore.
    task automatic send_step();
        lpg_pkg::lpg_in_t item;
        item.func    = lpg_pkg::FUNC_STEP;
        item.start_x = CB'($urandom);
        item.start_y = CB'($urandom);
        item.end_x   = CB'($urandom);
        item.end_y   = CB'($urandom);
        send_item(item);
    endtask

    task automatic send_steps(input int count);
        repeat (count) send_step();
    endtask

    // Stops sending until every predicted pixel has been transferred.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge aclk);
    endtask

    function automatic int random_coord();
        return int'($urandom_range(0, (1 << CB) - 1)) + COORD_MIN;
    endfunction

    // Moves from base by delta, reflecting when the end would leave the range.
    function automatic int fold_coord(input int base, input int delta);
        int pos;
        pos = base + delta;
        if (pos > COORD_MAX || pos < COORD_MIN)
            pos = base - delta;
        return pos;
    endfunction

    // Picks a line whose deltas stay within reach; optionally a diagonal.
    task automatic draw_line(input int reach, input bit diagonal,
                             output int sx, output int sy, output int ex, output int ey);
        int dx, dy;
        sx = random_coord();
        sy = random_coord();
        dx = int'($urandom_range(0, 2 * reach)) - reach;
        dy = int'($urandom_range(0, 2 * reach)) - reach;
        if (diagonal)
            dy = $urandom_range(0, 1) ? dx : -dx;
        ex = fold_coord(sx, dx);
        ey = fold_coord(sy, dy);
    endtask

    function automatic int run_length(input int sx, input int sy, input int ex, input int ey);
        int adx, ady;
        adx = (ex > sx) ? ex - sx : sx - ex;
        ady = (ey > sy) ? ey - sy : sy - ey;
        return (adx > ady) ? adx : ady;
    endfunction

    // A step with no line in progress after reset yields nothing.
    task automatic test_step_without_line();
        send_step();
    endtask

    // Horizontal with reversed endpoints and one step past the end,
    // vertical at the top corner, and a negative diagonal tie.
    task automatic test_line_kinds();
        send_load(9, COORD_MIN, 5, COORD_MIN);
        send_steps(5);
        send_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 3);
        send_steps(3);
        send_load(COORD_MIN, COORD_MAX, COORD_MIN + 3, COORD_MAX - 3);
        send_steps(3);
    endtask

    // A new load drops the line in progress.
    task automatic test_load_during_run();
        send_load(0, 0, 5, 2);
        send_steps(2);
        send_load(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_steps(2);
    endtask

    // Equal endpoints leave no line, so the following step yields nothing.
    task automatic test_zero_length();
        send_load(100, -100, 100, -100);
        send_step();
    endtask

    // Full span along x with a negative slope.
    task automatic test_extremes();
        send_load(COORD_MIN, COORD_MAX, COORD_MAX, 0);
        send_step();
    endtask

    // Random lines until the counted items reach the goal. Most are whole
    // short runs; some overrun, some are cut off by the next load, and some
    // items are full-range loads or stray steps.
    task automatic test_random_lines(input int goal);
        int sx, sy, ex, ey, span, roll, reach, steps;
        while (items_counted < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                reach = $urandom_range(0, 99);
                reach = (reach < 70) ? 16 : (reach < 95) ? 64 : 300;
                draw_line(reach, $urandom_range(0, 9) == 0, sx, sy, ex, ey);
                span = run_length(sx, sy, ex, ey);
                send_load(sx, sy, ex, ey);
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    steps = span;
                else if (roll < 87)
                    steps = span + $urandom_range(1, 3);
                else
                    steps = $urandom_range(0, span);
                send_steps(steps);
            end else if (roll < 90) begin
                send_load(random_coord(), random_coord(), random_coord(), random_coord());
                send_steps($urandom_range(0, 6));
            end else begin
                send_steps($urandom_range(1, 3));
            end
        end
    endtask

    // Whole runs with the sender holding off until the block has drained.
    task automatic test_drain_pause();
        int sx, sy, ex, ey;
        repeat (3) begin
            draw_line(16, 1'b0, sx, sy, ex, ey);
            send_load(sx, sy, ex, ey);
            send_steps(run_length(sx, sy, ex, ey));
            wait_drained();
            @(negedge aclk);
        end
    endtask

    // Result side: random ready stalls in short bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idling_on && aresetn && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Compare each pixel transfer with the oldest prediction.
    always @(posedge aclk) begin
        lpg_pkg::lpg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("Unexpected pixel transfer: pixel_x %0d, pixel_y %0d",
                       m_data.pixel_x, m_data.pixel_y);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.pixel_x !== want.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", want.pixel_x, m_data.pixel_x);
                    mismatch_count++;
                end
                if (m_data.pixel_y !== want.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", want.pixel_y, m_data.pixel_y);
                    mismatch_count++;
                end
                if (m_data.line_kind !== want.line_kind) begin
                    $error("line_kind: expected %0d, got %0d",
                           want.line_kind, m_data.line_kind);
                    mismatch_count++;
                end
                if (m_data.last_pixel !== want.last_pixel) begin
                    $error("last_pixel: expected %0d, got %0d",
                           want.last_pixel, m_data.last_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        clear_rasterizer();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_step_without_line();
        test_line_kinds();
        test_load_during_run();
        test_zero_length();
        test_extremes();
        test_random_lines(1000);
        test_drain_pause();
        // The last part of the run goes without idling on either side.
        idling_on = 1'b0;
        test_random_lines(1400);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatch_count += expected_pixels.size();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
